FILE: rtl/vcc_pkg.sv
// ----------------------------------------------------------------------------
// Valid-mode cross-correlation package
// Shared widths, transfer payload types, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package vcc_pkg;

    // Fixed field widths of the payload.
    localparam int SAMPLE_BITS        = 16;
    localparam int VALUE_BITS         = 38;
    localparam int PROD_BITS          = 2 * SAMPLE_BITS;
    localparam int TEMPLATE_DEPTH_DEF = 64;

    // Sample kinds carried in the mode field.
    localparam logic MODE_TEMPLATE = 1'b0;
    localparam logic MODE_SIGNAL   = 1'b1;

    // Input transfer payload.
    typedef struct packed {
        logic                          mode;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in_item;

    // Result transfer payload.
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         final_res;
        logic                         none;
        logic                         overflow;
    } t_out_item;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tmpl_we;
        logic hist_we;
        logic issue;
        logic acc_clear;
        logic load;
        logic res_final;
        logic res_none;
        logic res_ovf;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/vcc_ctrl.sv
// ----------------------------------------------------------------------------
// Valid-mode cross-correlation controller
// Tracks template length, window fill and phase, steps the multiply-
// accumulate sequence one tap per cycle and hands results to the datapath.
// ----------------------------------------------------------------------------
module vcc_ctrl #(
    parameter int TEMPLATE_DEPTH = vcc_pkg::TEMPLATE_DEPTH_DEF,
    localparam int AW = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1,
    localparam int LW = $clog2(TEMPLATE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vcc_pkg::t_in_item i_in_item,
    output vcc_pkg::t_dp_cmd  o_cmd,
    input  vcc_pkg::t_dp_sts  i_sts,
    output logic [AW-1:0]     o_tmpl_waddr,
    output logic [AW-1:0]     o_hist_waddr,
    output logic [AW-1:0]     o_rd_taddr,
    output logic [AW-1:0]     o_rd_haddr
);

    localparam int CW = LW + 1;

    vcc_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_count, n_count;
    logic            r_drop, n_drop;
    logic            r_phase, n_phase;
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_k, n_k;
    logic [AW-1:0]   r_haddr, n_haddr;
    logic            r_final, n_final;
    logic            r_none, n_none;
    logic            r_ovf, n_ovf;

    logic            accept;
    logic [AW-1:0]   wp_inc;
    logic [AW-1:0]   h_inc;
    logic [LW-1:0]   eff_len;
    logic [LW-1:0]   cnt_inc;
    logic [CW-1:0]   st_sum;
    logic [CW-1:0]   st_addr;

    // State and bookkeeping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vcc_pkg::ST_IDLE;
            r_len   <= '0;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_phase <= 1'b0;
            r_wp    <= '0;
            r_k     <= '0;
            r_haddr <= '0;
            r_final <= 1'b0;
            r_none  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_phase <= n_phase;
            r_wp    <= n_wp;
            r_k     <= n_k;
            r_haddr <= n_haddr;
            r_final <= n_final;
            r_none  <= n_none;
            r_ovf   <= n_ovf;
        end
    end

    // Helper arithmetic: circular pointer steps and window start address.
    assign accept  = i_in_valid && (r_state == vcc_pkg::ST_IDLE);
    assign wp_inc  = (r_wp == AW'(TEMPLATE_DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign h_inc   = (r_haddr == AW'(TEMPLATE_DEPTH - 1)) ? '0 : r_haddr + AW'(1);
    assign eff_len = r_phase ? '0 : r_len;
    assign cnt_inc = (r_count < r_len) ? r_count + LW'(1) : r_count;

    // The oldest sample of the window sits length-1 places behind the newest.
    assign st_sum  = CW'(wp_inc) + CW'(TEMPLATE_DEPTH) + CW'(1) - CW'(r_len);
    assign st_addr = (st_sum >= CW'(TEMPLATE_DEPTH)) ? st_sum - CW'(TEMPLATE_DEPTH) : st_sum;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_count = r_count;
        n_drop  = r_drop;
        n_phase = r_phase;
        n_wp    = r_wp;
        n_k     = r_k;
        n_haddr = r_haddr;
        n_final = r_final;
        n_none  = r_none;
        n_ovf   = r_ovf;

        o_cmd           = '0;
        o_cmd.res_final = r_final;
        o_cmd.res_none  = r_none;
        o_cmd.res_ovf   = r_ovf;

        unique case (r_state)
            vcc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_in_item.mode == vcc_pkg::MODE_TEMPLATE) begin
                        // A template sample after a signal starts a new template.
                        if (r_phase) begin
                            n_phase = 1'b0;
                            n_drop  = 1'b0;
                            n_count = '0;
                        end
                        if (eff_len < LW'(TEMPLATE_DEPTH)) begin
                            o_cmd.tmpl_we = 1'b1;
                            n_len         = eff_len + LW'(1);
                        end else begin
                            n_len  = eff_len;
                            n_drop = 1'b1;
                        end
                        if (i_in_item.last) begin
                            n_phase = 1'b1;
                        end
                    end else begin
                        // Signal sample: push into the history and check the window.
                        n_phase       = 1'b1;
                        o_cmd.hist_we = 1'b1;
                        n_wp          = wp_inc;
                        n_count       = cnt_inc;
                        n_ovf         = r_drop;
                        n_final       = i_in_item.last;
                        if (cnt_inc >= r_len) begin
                            n_none          = 1'b0;
                            o_cmd.acc_clear = 1'b1;
                            n_k             = '0;
                            n_haddr         = st_addr[AW-1:0];
                            n_state         = (r_len == '0) ? vcc_pkg::ST_DRAIN
                                                            : vcc_pkg::ST_RUN;
                            if (i_in_item.last) begin
                                n_count = '0;
                            end
                        end else if (i_in_item.last) begin
                            n_none  = 1'b1;
                            n_count = '0;
                            n_state = vcc_pkg::ST_DRAIN;
                        end
                    end
                end
            end
            vcc_pkg::ST_RUN: begin
                // One tap per cycle, template from index 0, history oldest first.
                o_cmd.issue = 1'b1;
                n_k         = r_k + AW'(1);
                n_haddr     = h_inc;
                if (LW'(r_k) == r_len - LW'(1)) begin
                    n_state = vcc_pkg::ST_DRAIN;
                end
            end
            vcc_pkg::ST_DRAIN: begin
                // Wait for the pipeline to empty and the output register to free.
                if (!i_sts.busy && i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = vcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vcc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready   = (r_state == vcc_pkg::ST_IDLE);
    assign o_tmpl_waddr = eff_len[AW-1:0];
    assign o_hist_waddr = wp_inc;
    assign o_rd_taddr   = r_k;
    assign o_rd_haddr   = r_haddr;

    // The window fill count never exceeds the template length.
    a_count_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_len)
        else $error("window count exceeds template length");

    // The template length never exceeds the store depth.
    a_len_le_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(TEMPLATE_DEPTH))
        else $error("template length exceeds depth");

    // Tap index stays inside the template while the sequence runs.
    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vcc_pkg::ST_RUN) |-> (LW'(r_k) < r_len))
        else $error("tap index beyond template length");

endmodule

FILE: rtl/vcc_datapath.sv
// ----------------------------------------------------------------------------
// Valid-mode cross-correlation datapath
// Template and signal history memories, a registered multiplier, the
// accumulator and the result output register.
// ----------------------------------------------------------------------------
module vcc_datapath #(
    parameter int TEMPLATE_DEPTH = vcc_pkg::TEMPLATE_DEPTH_DEF,
    localparam int AW = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  vcc_pkg::t_dp_cmd                       i_cmd,
    output vcc_pkg::t_dp_sts                       o_sts,
    input  logic signed [vcc_pkg::SAMPLE_BITS-1:0] i_wdata,
    input  logic [AW-1:0]                          i_tmpl_waddr,
    input  logic [AW-1:0]                          i_hist_waddr,
    input  logic [AW-1:0]                          i_rd_taddr,
    input  logic [AW-1:0]                          i_rd_haddr,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output vcc_pkg::t_out_item                     o_out_item
);

    logic signed [vcc_pkg::SAMPLE_BITS-1:0] tmpl_mem [TEMPLATE_DEPTH];
    logic signed [vcc_pkg::SAMPLE_BITS-1:0] hist_mem [TEMPLATE_DEPTH];

    logic signed [vcc_pkg::SAMPLE_BITS-1:0] r_tq;
    logic signed [vcc_pkg::SAMPLE_BITS-1:0] r_hq;
    logic signed [vcc_pkg::PROD_BITS-1:0]   r_prod;
    logic signed [vcc_pkg::VALUE_BITS-1:0]  r_acc;
    logic                                   r_rd_v;
    logic                                   r_mul_v;
    vcc_pkg::t_out_item                     r_out;
    logic                                   r_out_valid;

    // Template memory: written while loading, read one tap per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.tmpl_we) begin
            tmpl_mem[i_tmpl_waddr] <= i_wdata;
        end
        r_tq <= tmpl_mem[i_rd_taddr];
    end

    // Signal history memory: a circular buffer of the latest samples.
    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_we) begin
            hist_mem[i_hist_waddr] <= i_wdata;
        end
        r_hq <= hist_mem[i_rd_haddr];
    end

    // Pipeline valid flags for the read and multiply stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
        end else begin
            r_rd_v  <= i_cmd.issue;
            r_mul_v <= r_rd_v;
        end
    end

    // Registered product, then accumulation that wraps at the value width.
    always_ff @(posedge i_clk) begin
        r_prod <= r_tq * r_hq;
        if (i_cmd.acc_clear) begin
            r_acc <= '0;
        end else if (r_mul_v) begin
            r_acc <= r_acc + vcc_pkg::VALUE_BITS'(r_prod);
        end
    end

    // Output register: holds a result until the receiver takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.value     <= i_cmd.res_none ? '0 : r_acc;
            r_out.final_res <= i_cmd.res_final;
            r_out.none      <= i_cmd.res_none;
            r_out.overflow  <= i_cmd.res_ovf;
        end
    end

    assign o_sts.busy     = r_rd_v || r_mul_v;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;

    // A product is only accumulated after a read that fed it.
    a_mul_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_v |-> $past(r_rd_v))
        else $error("multiply stage valid without a preceding read");

    // A result flagged as having no window carries a zero sum.
    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.none) |-> (r_out.value == '0))
        else $error("no-window result carries a nonzero value");

endmodule

FILE: rtl/valid_cross_correlation_core.sv
// ----------------------------------------------------------------------------
// Valid-mode cross-correlation core
// Loads a template, then streams signal samples and returns the exact
// integer correlation sum for every full template-length window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries template
//   samples (mode 0) followed by signal samples (mode 1). The last mark ends
//   a template or a signal. A template sample after a signal starts a new
//   template; template samples beyond TEMPLATE_DEPTH are dropped and the
//   overflow flag is set on later results.
//   Output channel (o_out_valid / i_out_ready / o_out_item) carries one
//   result per signal sample that completes a window, or a single result
//   flagged none when a signal ends before a full window exists.
//   Timing: a template sample, and a signal sample that gives no result,
//   leave the core idle. A signal sample that completes a window steps the
//   single multiply-accumulate unit one tap per cycle through its read,
//   multiply and accumulate registers; the result is loaded into the output
//   register once they have emptied and that register is free, and no sample
//   is accepted until then. A result with no taps to sum (an empty template,
//   or a signal that ended early) is loaded as soon as that register is free.
//   Reset clears the template length, window count and phase; memories keep
//   their contents. A stalled receiver holds the result in the output
//   register; samples that give no result are still accepted meanwhile.
// ----------------------------------------------------------------------------
module valid_cross_correlation_core #(
    parameter int TEMPLATE_DEPTH = vcc_pkg::TEMPLATE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  vcc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vcc_pkg::t_out_item o_out_item
);

    localparam int AW = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1;

    vcc_pkg::t_dp_cmd cmd;
    vcc_pkg::t_dp_sts sts;
    logic [AW-1:0]    tmpl_waddr;
    logic [AW-1:0]    hist_waddr;
    logic [AW-1:0]    rd_taddr;
    logic [AW-1:0]    rd_haddr;

    // Sequencing and bookkeeping.
    vcc_ctrl #(
        .TEMPLATE_DEPTH(TEMPLATE_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_cmd        (cmd),
        .i_sts        (sts),
        .o_tmpl_waddr (tmpl_waddr),
        .o_hist_waddr (hist_waddr),
        .o_rd_taddr   (rd_taddr),
        .o_rd_haddr   (rd_haddr)
    );

    // Storage, multiply-accumulate and output register.
    vcc_datapath #(
        .TEMPLATE_DEPTH(TEMPLATE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_wdata      (i_in_item.sample),
        .i_tmpl_waddr (tmpl_waddr),
        .i_hist_waddr (hist_waddr),
        .i_rd_taddr   (rd_taddr),
        .i_rd_haddr   (rd_haddr),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

FILE: test/valid_cross_correlation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Valid-mode cross-correlation result checker
// Watches both transfer channels of the correlation core. It keeps its own
// copy of the template, the signal window and the phase. It predicts the
// correlation result of each accepted sample that gives one and compares each
// result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module valid_cross_correlation_checker #(
    parameter int TEMPLATE_DEPTH = vcc_pkg::TEMPLATE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  vcc_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  vcc_pkg::t_out_item i_out_item,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    // Predicted state of the core.
    logic signed [vcc_pkg::SAMPLE_BITS-1:0] tmpl_taps  [TEMPLATE_DEPTH];
    logic signed [vcc_pkg::SAMPLE_BITS-1:0] sig_window [TEMPLATE_DEPTH];
    int unsigned                            tmpl_len;
    int unsigned                            win_fill;
    logic                                   tmpl_dropped;
    logic                                   streaming;

    // Correlation results still to arrive, oldest first.
    vcc_pkg::t_out_item pending_sums[$];
    int                 mismatch_total = 0;

    // Exact sum of template taps times the newest window samples.
    function automatic logic signed [vcc_pkg::VALUE_BITS-1:0] window_corr();
        logic signed [63:0] acc;
        int                 k;
        acc = '0;
        for (k = 0; k < int'(tmpl_len); k++) begin
            acc += 64'(tmpl_taps[k]) * 64'(sig_window[int'(tmpl_len) - 1 - k]);
        end
        return acc[vcc_pkg::VALUE_BITS-1:0];
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: result mismatch on %s: got %0d, wanted %0d", $time, what, got, want);
        mismatch_total++;
    endtask

    // Advances the predicted state by one accepted sample.
    task automatic correlate_sample(input vcc_pkg::t_in_item it);
        vcc_pkg::t_out_item r;
        int                 i;
        if (it.mode == vcc_pkg::MODE_TEMPLATE) begin
            // A template sample after a signal starts a new template.
            if (streaming) begin
                tmpl_len     = 0;
                tmpl_dropped = 1'b0;
                win_fill     = 0;
                streaming    = 1'b0;
            end
            if (tmpl_len < TEMPLATE_DEPTH) begin
                tmpl_taps[tmpl_len] = it.sample;
                tmpl_len++;
            end else begin
                tmpl_dropped = 1'b1;
            end
            if (it.last) begin
                streaming = 1'b1;
            end
        end else begin
            streaming = 1'b1;
            for (i = TEMPLATE_DEPTH - 1; i > 0; i--) begin
                sig_window[i] = sig_window[i-1];
            end
            sig_window[0] = it.sample;
            if (win_fill < tmpl_len) begin
                win_fill++;
            end
            if (win_fill >= tmpl_len) begin
                r.value     = window_corr();
                r.final_res = it.last;
                r.none      = 1'b0;
                r.overflow  = tmpl_dropped;
                pending_sums.push_back(r);
                if (it.last) begin
                    win_fill = 0;
                end
            end else if (it.last) begin
                // The signal ended before a full window existed.
                r.value     = '0;
                r.final_res = 1'b1;
                r.none      = 1'b1;
                r.overflow  = tmpl_dropped;
                pending_sums.push_back(r);
                win_fill = 0;
            end
        end
    endtask

    // Compares one result transfer with the oldest prediction.
    task automatic compare_result(input vcc_pkg::t_out_item got);
        vcc_pkg::t_out_item want;
        if (pending_sums.size() == 0) begin
            report_mismatch("result with nothing pending", longint'(got.value), longint'(0));
        end else begin
            want = pending_sums.pop_front();
            if (got.value !== want.value) begin
                report_mismatch("value", longint'(got.value), longint'(want.value));
            end
            if (got.final_res !== want.final_res) begin
                report_mismatch("final_res", longint'(got.final_res),
                                longint'(want.final_res));
            end
            if (got.none !== want.none) begin
                report_mismatch("none", longint'(got.none), longint'(want.none));
            end
            if (got.overflow !== want.overflow) begin
                report_mismatch("overflow", longint'(got.overflow),
                                longint'(want.overflow));
            end
        end
    endtask

    // Both channels are sampled at the clock edge where the transfer happens.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tmpl_len     = 0;
            win_fill     = 0;
            tmpl_dropped = 1'b0;
            streaming    = 1'b0;
            pending_sums.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                correlate_sample(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                compare_result(i_out_item);
            end
        end
        o_outstanding <= pending_sums.size();
        o_mismatches  <= mismatch_total;
    end

endmodule

FILE: test/valid_cross_correlation_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Valid-mode cross-correlation core testbench
// Loads templates and streams signals through the core: a directed opening
// with extreme samples and every phase change, then random template and
// signal sequences mixed with stray samples. Sender bursts and receiver
// stalls vary throughout. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module valid_cross_correlation_core_tb;

    localparam int ITEM_TARGET    = 1450;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 100;

    // Sample flavors.
    localparam int FLAVOR_RANDOM  = 0;
    localparam int FLAVOR_EXTREME = 1;
    localparam int FLAVOR_MIN     = 2;

    // Receiver stall styles.
    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_SPARSE   = 2;
    localparam int STALL_PERIODIC = 3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    vcc_pkg::t_in_item  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    vcc_pkg::t_out_item out_item;
    logic               hold_req  = 1'b0;

    int mismatches;
    int outstanding;
    int sent_items  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    logic steady    = 1'b0;

    always #5 clk = ~clk;

    valid_cross_correlation_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    valid_cross_correlation_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Picks a sample value of the given flavor.
    function automatic logic signed [vcc_pkg::SAMPLE_BITS-1:0] pick_sample(input int flavor);
        logic signed [vcc_pkg::SAMPLE_BITS-1:0] s;
        s = vcc_pkg::SAMPLE_BITS'($urandom);
        if (flavor == FLAVOR_MIN) begin
            s = {1'b1, {(vcc_pkg::SAMPLE_BITS-1){1'b0}}};
        end else if (flavor == FLAVOR_EXTREME) begin
            case ($urandom_range(0, 4))
                0: s = {1'b1, {(vcc_pkg::SAMPLE_BITS-1){1'b0}}};
                1: s = {1'b0, {(vcc_pkg::SAMPLE_BITS-1){1'b1}}};
                2: s = '0;
                3: s = '1;
                default: s = vcc_pkg::SAMPLE_BITS'(1);
            endcase
        end
        return s;
    endfunction

    // Offers one sample and returns at the edge where its transfer happens.
    task automatic offer(input logic mode,
                         input logic signed [vcc_pkg::SAMPLE_BITS-1:0] sample,
                         input logic last);
        vcc_pkg::t_in_item it;
        it.mode   = mode;
        it.sample = sample;
        it.last   = last;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (!steady) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        sent_items++;
    endtask

    // Holds the sender back until every predicted result has arrived.
    task automatic pause_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Receiver: stalls on changing styles, plus one long hold-off on request.
    initial begin : receiver
        int   style;
        int   style_left;
        int   hold_left;
        logic hold_taken;
        style      = STALL_NONE;
        style_left = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(STALL_NONE, STALL_PERIODIC);
                    style_left = $urandom_range(16, 160);
                end
                style_left--;
                case (style)
                    STALL_NONE:   out_ready <= 1'b1;
                    STALL_RANDOM: out_ready <= 1'($urandom_range(0, 1));
                    STALL_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:      out_ready <= (style_left % 5 != 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int seq_idx;
        int flavor;
        int pick;
        int tlen;
        int eff_len;
        int slen;
        int nsig;
        int i;
        int j;
        int k;
        logic tmpl_mark;
        logic sig_mark;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: empty template, extremes and phase changes.
        offer(vcc_pkg::MODE_SIGNAL, 16'sd1234, 1'b0);
        offer(vcc_pkg::MODE_SIGNAL, -16'sd1, 1'b1);
        offer(vcc_pkg::MODE_TEMPLATE, -16'sd32768, 1'b0);
        offer(vcc_pkg::MODE_TEMPLATE, -16'sd32768, 1'b0);
        offer(vcc_pkg::MODE_TEMPLATE, 16'sd32767, 1'b1);
        offer(vcc_pkg::MODE_SIGNAL, -16'sd32768, 1'b0);
        offer(vcc_pkg::MODE_SIGNAL, -16'sd32768, 1'b0);
        offer(vcc_pkg::MODE_SIGNAL, 16'sd32767, 1'b0);
        offer(vcc_pkg::MODE_SIGNAL, 16'sd0, 1'b0);
        offer(vcc_pkg::MODE_SIGNAL, -16'sd1, 1'b1);
        // New template without a last mark; the signal ends it implicitly.
        offer(vcc_pkg::MODE_TEMPLATE, 16'sd32767, 1'b0);
        offer(vcc_pkg::MODE_TEMPLATE, -16'sd32768, 1'b0);
        offer(vcc_pkg::MODE_SIGNAL, 16'sd5, 1'b1);
        offer(vcc_pkg::MODE_SIGNAL, 16'sd7, 1'b0);
        offer(vcc_pkg::MODE_SIGNAL, 16'sd8, 1'b0);
        // New template in the middle of a signal, then a too-short signal.
        offer(vcc_pkg::MODE_TEMPLATE, 16'sh5555, 1'b0);
        offer(vcc_pkg::MODE_TEMPLATE, -16'sd21846, 1'b1);
        offer(vcc_pkg::MODE_SIGNAL, 16'sd32767, 1'b1);
        offer(vcc_pkg::MODE_SIGNAL, 16'sd1, 1'b0);
        offer(vcc_pkg::MODE_SIGNAL, 16'sd2, 1'b1);

        // Long receiver hold-off while the sender keeps offering samples.
        pause_for_results();
        steady   = 1'b1;
        hold_req <= 1'b1;
        offer(vcc_pkg::MODE_TEMPLATE, pick_sample(FLAVOR_RANDOM), 1'b0);
        offer(vcc_pkg::MODE_TEMPLATE, pick_sample(FLAVOR_RANDOM), 1'b1);
        for (k = 0; k < 20; k++) begin
            offer(vcc_pkg::MODE_SIGNAL, pick_sample(FLAVOR_RANDOM), k == 19);
        end

        // Random template and signal sequences.
        seq_idx = 0;
        while (sent_items < ITEM_TARGET) begin
            steady = ($urandom_range(0, 4) == 0);
            flavor = ($urandom_range(0, 9) == 0) ? FLAVOR_EXTREME : FLAVOR_RANDOM;
            if ($urandom_range(0, 19) == 0) begin
                pause_for_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                tlen = $urandom_range(1, 8);
            end else if (pick < 85) begin
                tlen = $urandom_range(9, 32);
            end else if (pick < 96) begin
                tlen = $urandom_range(33, 64);
            end else begin
                tlen = $urandom_range(65, 70);
            end
            // The first sequence drives the largest possible sum.
            if (seq_idx == 0) begin
                tlen   = 66;
                flavor = FLAVOR_MIN;
            end
            eff_len   = (tlen > 64) ? 64 : tlen;
            tmpl_mark = ($urandom_range(0, 3) != 0);
            for (i = 0; i < tlen; i++) begin
                offer(vcc_pkg::MODE_TEMPLATE, pick_sample(flavor),
                      (i == tlen - 1) && tmpl_mark);
            end
            nsig = $urandom_range(1, 3);
            for (j = 0; j < nsig; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    slen = eff_len + $urandom_range(0, 10);
                end else if (pick < 90) begin
                    slen = $urandom_range(1, eff_len);
                end else begin
                    slen = $urandom_range(1, 6);
                end
                sig_mark = ($urandom_range(0, 9) != 0);
                for (k = 0; k < slen; k++) begin
                    offer(vcc_pkg::MODE_SIGNAL, pick_sample(flavor),
                          (k == slen - 1) && sig_mark);
                end
            end
            // Stray samples with random mode and last mark.
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    offer(1'($urandom_range(0, 1)), pick_sample(FLAVOR_RANDOM),
                          1'($urandom_range(0, 1)));
                end
            end
            seq_idx++;
        end

        // Drain, then let the core settle before the verdict.
        pause_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
